/* hdl/tbpc_pkg.sv */
// ----------------------------------------------------------------------------
// Three-button press classifier package
// Shared types, register indexes and event codes.
// ----------------------------------------------------------------------------
package tbpc_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int STAMP_W     = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int EVENT_W     = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT   = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd800;
  localparam logic [CFG_W-1:0] REPEAT_RESET   = 16'd150;

  localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
  localparam logic [EVENT_W-1:0] EV_UP_SHORT     = 3'd1;
  localparam logic [EVENT_W-1:0] EV_UP_LONG      = 3'd2;
  localparam logic [EVENT_W-1:0] EV_UP_HELD      = 3'd3;
  localparam logic [EVENT_W-1:0] EV_DOWN_SHORT   = 3'd4;
  localparam logic [EVENT_W-1:0] EV_DOWN_LONG    = 3'd5;
  localparam logic [EVENT_W-1:0] EV_DOWN_HELD    = 3'd6;
  localparam logic [EVENT_W-1:0] EV_SELECT_SHORT = 3'd7;

  localparam int LANE_UP     = 0;
  localparam int LANE_DOWN   = 1;
  localparam int LANE_SELECT = 2;

  typedef enum logic [1:0] {
    KIND_SHORT,
    KIND_LONG,
    KIND_HELD
  } press_kind_t;

  typedef struct packed {
    logic [CFG_W-1:0] settle_ms;
    logic [CFG_W-1:0] hold_ms;
    logic [CFG_W-1:0] repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic        fire;
    press_kind_t kind;
    logic        level;
  } lane_res_t;

endpackage

/* hdl/three_button_press_classifier_unit.sv */
// ----------------------------------------------------------------------------
// Three-button press classifier
// The result of an accepted poll is registered and shown on the master side in the next cycle.
// Throughput: one poll per cycle, set by the lane state update, while the master side takes the results.
// Three button lanes run side by side; a merge stage picks the event.
// Reset (synchronous) restores the default timings and all button state.
// ----------------------------------------------------------------------------
module three_button_press_classifier_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // now_ms[31:0], raw_up[32], raw_down[33], raw_select[34], zero fill
  input  logic [39:0]                      s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // event_res[2:0], up_pressed[3], down_pressed[4], select_pressed[5], zero fill
  output logic [7:0]                       m_tdata,
  input  logic                             cfg_we,
  input  logic [tbpc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tbpc_pkg::CFG_W-1:0]       cfg_data
);

  tbpc_pkg::cfg_t                                   cfg;
  tbpc_pkg::lane_res_t [tbpc_pkg::NUM_BUTTONS-1:0]  lane_res;
  logic [tbpc_pkg::NUM_BUTTONS-1:0]                 run;
  logic [tbpc_pkg::NUM_BUTTONS-1:0]                 raw;
  logic [tbpc_pkg::NUM_BUTTONS-1:0]                 is_scroll;
  logic [tbpc_pkg::EVENT_W-1:0]                     event_res;
  logic [tbpc_pkg::STAMP_W-1:0]                     now_ms;
  logic                                             accept;

  assign now_ms    = s_tdata[tbpc_pkg::STAMP_W-1:0];
  assign raw       = s_tdata[tbpc_pkg::STAMP_W +: tbpc_pkg::NUM_BUTTONS];
  assign is_scroll = 3'b011;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ms <= tbpc_pkg::DEBOUNCE_RESET;
      cfg.hold_ms   <= tbpc_pkg::HOLD_RESET;
      cfg.repeat_ms <= tbpc_pkg::REPEAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tbpc_pkg::REG_DEBOUNCE: cfg.settle_ms <= cfg_data;
        tbpc_pkg::REG_HOLD:     cfg.hold_ms   <= cfg_data;
        tbpc_pkg::REG_REPEAT:   cfg.repeat_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < tbpc_pkg::NUM_BUTTONS; i++) begin : g_lane
    tbpc_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .accept    (accept),
      .is_scroll (is_scroll[i]),
      .now_ms    (now_ms),
      .raw       (raw[i]),
      .cfg       (cfg),
      .run       (run[i]),
      .res       (lane_res[i])
    );
  end

  tbpc_merge u_merge (
    .lane_res  (lane_res),
    .run       (run),
    .event_res (event_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00,
                  lane_res[tbpc_pkg::LANE_SELECT].level,
                  lane_res[tbpc_pkg::LANE_DOWN].level,
                  lane_res[tbpc_pkg::LANE_UP].level,
                  event_res};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted request produced no result");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[2:0] == tbpc_pkg::EV_SELECT_SHORT)) |-> !m_tdata[5])
    else $error("select short event while select still pressed");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tdata[2:0] == tbpc_pkg::EV_UP_LONG)
                  || (m_tdata[2:0] == tbpc_pkg::EV_UP_HELD))) |-> m_tdata[3])
    else $error("up long or held event while up released");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[2:0] == tbpc_pkg::EV_DOWN_SHORT)) |-> !m_tdata[4])
    else $error("down short event while down still pressed");

endmodule

/* hdl/tbpc_lane.sv */
// ----------------------------------------------------------------------------
// Button lane
// Debounces one button and classifies its press for the current poll.
// ----------------------------------------------------------------------------
module tbpc_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          is_scroll,
  input  logic [tbpc_pkg::STAMP_W-1:0]  now_ms,
  input  logic                          raw,
  input  tbpc_pkg::cfg_t                cfg,
  input  logic                          run,
  output tbpc_pkg::lane_res_t           res
);

  logic                         stable_level;
  logic                         previous_raw;
  logic                         press_seen;
  logic [tbpc_pkg::STAMP_W-1:0] change_stamp;
  logic [tbpc_pkg::STAMP_W-1:0] press_stamp;
  logic                         long_sent;
  logic [tbpc_pkg::STAMP_W-1:0] repeat_stamp;

  logic                         raw_change;
  logic [tbpc_pkg::STAMP_W-1:0] since_change;
  logic [tbpc_pkg::STAMP_W-1:0] since_press;
  logic [tbpc_pkg::STAMP_W-1:0] since_repeat;
  logic                         take;
  logic                         new_press;
  logic                         level_next;
  logic                         long_eff;
  logic                         hold_done;
  logic                         repeat_done;
  logic                         fire_long;
  logic                         fire_held;
  logic                         fire_short;
  logic                         press_seen_next;

  always_comb begin
    raw_change   = raw != previous_raw;
    since_change = now_ms - change_stamp;
    since_press  = now_ms - press_stamp;
    since_repeat = now_ms - repeat_stamp;
    take         = !raw_change
                   && (since_change > {{(tbpc_pkg::STAMP_W-tbpc_pkg::CFG_W){1'b0}},
                                       cfg.settle_ms})
                   && (raw != stable_level);
    new_press    = take && raw;
    level_next   = take ? raw : stable_level;
    long_eff     = is_scroll && !new_press && long_sent;
    // A press recorded in this poll has zero elapsed time.
    hold_done    = new_press ? (cfg.hold_ms == '0)
                   : (since_press >= {{(tbpc_pkg::STAMP_W-tbpc_pkg::CFG_W){1'b0}},
                                      cfg.hold_ms});
    repeat_done  = since_repeat >= {{(tbpc_pkg::STAMP_W-tbpc_pkg::CFG_W){1'b0}},
                                    cfg.repeat_ms};
    fire_long    = is_scroll && level_next && !long_eff && hold_done;
    fire_held    = is_scroll && level_next && long_eff && repeat_done;
    fire_short   = !level_next && press_seen && !long_eff;

    if (level_next) begin
      press_seen_next = (fire_long || fire_held) ? press_seen : 1'b1;
    end else begin
      press_seen_next = 1'b0;
    end

    res.fire  = fire_long || fire_held || fire_short;
    res.level = level_next;
    if (fire_long) begin
      res.kind = tbpc_pkg::KIND_LONG;
    end else if (fire_held) begin
      res.kind = tbpc_pkg::KIND_HELD;
    end else begin
      res.kind = tbpc_pkg::KIND_SHORT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level <= 1'b0;
      previous_raw <= 1'b1;
      press_seen   <= 1'b0;
      change_stamp <= '0;
      press_stamp  <= '0;
      long_sent    <= 1'b0;
      repeat_stamp <= '0;
    end else if (accept) begin
      previous_raw <= raw;
      stable_level <= level_next;
      if (raw_change) begin
        change_stamp <= now_ms;
      end
      if (new_press) begin
        press_stamp <= now_ms;
      end
      if (run) begin
        press_seen <= press_seen_next;
      end
      if (run && fire_long) begin
        long_sent    <= 1'b1;
        repeat_stamp <= now_ms;
      end else if (run && fire_held) begin
        repeat_stamp <= now_ms;
      end else if (new_press) begin
        long_sent    <= 1'b0;
        repeat_stamp <= '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (accept && run && fire_long) |=> long_sent)
    else $error("long event did not mark the press as long");

  assert property (@(posedge clk) disable iff (rst)
    (accept && run && !level_next) |=> !press_seen)
    else $error("press seen flag survived a release");

  assert property (@(posedge clk) disable iff (rst)
    !is_scroll |-> !(fire_long || fire_held))
    else $error("select lane gave a long or held event");

endmodule

/* hdl/tbpc_merge.sv */
// ----------------------------------------------------------------------------
// Lane merge
// Picks the first firing lane in priority order and forms the event code.
// ----------------------------------------------------------------------------
module tbpc_merge (
  input  tbpc_pkg::lane_res_t [tbpc_pkg::NUM_BUTTONS-1:0] lane_res,
  output logic [tbpc_pkg::NUM_BUTTONS-1:0]                run,
  output logic [tbpc_pkg::EVENT_W-1:0]                    event_res
);

  always_comb begin
    run[tbpc_pkg::LANE_UP]     = 1'b1;
    run[tbpc_pkg::LANE_DOWN]   = !lane_res[tbpc_pkg::LANE_UP].fire;
    run[tbpc_pkg::LANE_SELECT] = !lane_res[tbpc_pkg::LANE_UP].fire
                                 && !lane_res[tbpc_pkg::LANE_DOWN].fire;
    event_res = tbpc_pkg::EV_NONE;
    if (lane_res[tbpc_pkg::LANE_UP].fire) begin
      case (lane_res[tbpc_pkg::LANE_UP].kind)
        tbpc_pkg::KIND_LONG: event_res = tbpc_pkg::EV_UP_LONG;
        tbpc_pkg::KIND_HELD: event_res = tbpc_pkg::EV_UP_HELD;
        default:             event_res = tbpc_pkg::EV_UP_SHORT;
      endcase
    end else if (lane_res[tbpc_pkg::LANE_DOWN].fire) begin
      case (lane_res[tbpc_pkg::LANE_DOWN].kind)
        tbpc_pkg::KIND_LONG: event_res = tbpc_pkg::EV_DOWN_LONG;
        tbpc_pkg::KIND_HELD: event_res = tbpc_pkg::EV_DOWN_HELD;
        default:             event_res = tbpc_pkg::EV_DOWN_SHORT;
      endcase
    end else if (lane_res[tbpc_pkg::LANE_SELECT].fire) begin
      event_res = tbpc_pkg::EV_SELECT_SHORT;
    end
  end

endmodule

/* tb/press_event_checker.sv */
// ----------------------------------------------------------------------------
// Press event checker
// Watches the poll and event streams and the register port of the
// three-button press classifier. It keeps its own model of the debounce,
// long-press and auto-repeat state, predicts the event and the debounced
// levels for every accepted poll request, and compares each accepted result
// against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module press_event_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [39:0]                     s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [7:0]                      m_tdata,
  input  logic                            cfg_we,
  input  logic [tbpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tbpc_pkg::CFG_W-1:0]      cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              events_seen
);

  typedef struct packed {
    logic                         select_on;
    logic                         down_on;
    logic                         up_on;
    logic [tbpc_pkg::EVENT_W-1:0] event_code;
  } poll_result_t;

  poll_result_t expected_results[$];

  logic [tbpc_pkg::CFG_W-1:0]       settle_cfg;
  logic [tbpc_pkg::CFG_W-1:0]       hold_cfg;
  logic [tbpc_pkg::CFG_W-1:0]       repeat_cfg;
  logic [tbpc_pkg::NUM_BUTTONS-1:0] level_q;
  logic [tbpc_pkg::NUM_BUTTONS-1:0] raw_prev_q;
  logic [tbpc_pkg::NUM_BUTTONS-1:0] seen_q;
  logic [tbpc_pkg::NUM_BUTTONS-1:0] long_fired;
  logic [tbpc_pkg::STAMP_W-1:0]     change_at[tbpc_pkg::NUM_BUTTONS];
  logic [tbpc_pkg::STAMP_W-1:0]     press_at[tbpc_pkg::NUM_BUTTONS];
  logic [tbpc_pkg::STAMP_W-1:0]     repeat_at[tbpc_pkg::NUM_BUTTONS];

  task automatic clear_model();
    settle_cfg = tbpc_pkg::DEBOUNCE_RESET;
    hold_cfg   = tbpc_pkg::HOLD_RESET;
    repeat_cfg = tbpc_pkg::REPEAT_RESET;
    level_q    = '0;
    raw_prev_q = '1;
    seen_q     = '0;
    long_fired = '0;
    for (int b = 0; b < tbpc_pkg::NUM_BUTTONS; b++) begin
      change_at[b] = '0;
      press_at[b]  = '0;
      repeat_at[b] = '0;
    end
  endtask

  // Up and down lanes: short on a release with no long event, long after the hold
  // time, then held events at the repeat interval.
  task automatic scroll_lane(input int b, input logic [tbpc_pkg::EVENT_W-1:0] short_ev,
                             input logic [tbpc_pkg::EVENT_W-1:0] long_ev,
                             input logic [tbpc_pkg::EVENT_W-1:0] held_ev,
                             input logic [tbpc_pkg::STAMP_W-1:0] now,
                             output logic [tbpc_pkg::EVENT_W-1:0] ev);
    logic [tbpc_pkg::STAMP_W-1:0] since_press;
    logic [tbpc_pkg::STAMP_W-1:0] since_repeat;
    since_press  = now - press_at[b];
    since_repeat = now - repeat_at[b];
    ev = tbpc_pkg::EV_NONE;
    if (level_q[b]) begin
      if (!long_fired[b] && since_press >= hold_cfg) begin
        long_fired[b] = 1'b1;
        repeat_at[b]  = now;
        ev = long_ev;
      end else if (long_fired[b] && since_repeat >= repeat_cfg) begin
        repeat_at[b] = now;
        ev = held_ev;
      end
    end else if (seen_q[b]) begin
      seen_q[b] = 1'b0;
      if (!long_fired[b]) ev = short_ev;
    end
    if (ev == tbpc_pkg::EV_NONE && level_q[b] && !seen_q[b]) seen_q[b] = 1'b1;
  endtask

  task automatic classify_poll(input logic [tbpc_pkg::STAMP_W-1:0] now,
                               input logic [tbpc_pkg::NUM_BUTTONS-1:0] raw,
                               output poll_result_t res);
    logic [tbpc_pkg::STAMP_W-1:0] quiet;
    logic [tbpc_pkg::EVENT_W-1:0] ev;
    for (int b = 0; b < tbpc_pkg::NUM_BUTTONS; b++) begin
      if (raw[b] != raw_prev_q[b]) change_at[b] = now;
      raw_prev_q[b] = raw[b];
      quiet = now - change_at[b];
      if (quiet > settle_cfg && raw[b] != level_q[b]) begin
        level_q[b] = raw[b];
        if (raw[b]) begin
          press_at[b] = now;
          if (b != tbpc_pkg::LANE_SELECT) begin
            long_fired[b] = 1'b0;
            repeat_at[b]  = '0;
          end
        end
      end
    end
    scroll_lane(tbpc_pkg::LANE_UP, tbpc_pkg::EV_UP_SHORT, tbpc_pkg::EV_UP_LONG,
                tbpc_pkg::EV_UP_HELD, now, ev);
    if (ev == tbpc_pkg::EV_NONE) begin
      scroll_lane(tbpc_pkg::LANE_DOWN, tbpc_pkg::EV_DOWN_SHORT, tbpc_pkg::EV_DOWN_LONG,
                  tbpc_pkg::EV_DOWN_HELD, now, ev);
    end
    if (ev == tbpc_pkg::EV_NONE) begin
      if (!level_q[tbpc_pkg::LANE_SELECT] && seen_q[tbpc_pkg::LANE_SELECT]) begin
        seen_q[tbpc_pkg::LANE_SELECT] = 1'b0;
        ev = tbpc_pkg::EV_SELECT_SHORT;
      end else if (level_q[tbpc_pkg::LANE_SELECT] && !seen_q[tbpc_pkg::LANE_SELECT]) begin
        seen_q[tbpc_pkg::LANE_SELECT] = 1'b1;
      end
    end
    res.event_code = ev;
    res.up_on      = level_q[tbpc_pkg::LANE_UP];
    res.down_on    = level_q[tbpc_pkg::LANE_DOWN];
    res.select_on  = level_q[tbpc_pkg::LANE_SELECT];
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    poll_result_t got;
    poll_result_t want;
    if (rst) begin
      clear_model();
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[5:0];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got 0x%02h", $time, m_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("event", want.event_code, got.event_code);
          check_field("up_pressed", want.up_on, got.up_on);
          check_field("down_pressed", want.down_on, got.down_on);
          check_field("select_pressed", want.select_on, got.select_on);
          if (want.event_code != tbpc_pkg::EV_NONE) events_seen++;
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          tbpc_pkg::REG_DEBOUNCE: settle_cfg = cfg_data;
          tbpc_pkg::REG_HOLD:     hold_cfg = cfg_data;
          tbpc_pkg::REG_REPEAT:   repeat_cfg = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        classify_poll(s_tdata[31:0], s_tdata[34:32], want);
        expected_results.push_back(want);
      end
    end
    pending = expected_results.size();
  end

endmodule

/* tb/tb_three_button_press_classifier_unit.sv */
// ----------------------------------------------------------------------------
// Three-button press classifier testbench
// Drives poll requests with debounced press scripts, contact bounce, wrapping
// and backward timestamps under several timing settings, with random idling
// on both streams and one long result stall. A separate checker predicts and
// compares every result; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_three_button_press_classifier_unit;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [tbpc_pkg::CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [39:0]                     s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [7:0]                      m_tdata;
  logic                            cfg_we = 1'b0;
  logic [tbpc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [tbpc_pkg::CFG_W-1:0]      cfg_data = '0;

  int fail_count;
  int pending;
  int events_seen;
  int send_idle = 24;
  int recv_idle = 61;
  bit hold_off_req = 1'b0;
  int polls_sent = 0;
  int settings_used = 1;
  int cycle_count = 0;

  three_button_press_classifier_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  press_event_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .events_seen (events_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, pending);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with the request still offered, so the next call can replace it.
  task automatic send_poll(input logic [tbpc_pkg::STAMP_W-1:0] now, input logic [2:0] raw);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, raw, now};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    polls_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_timing(input logic [tbpc_pkg::CFG_W-1:0] deb,
                            input logic [tbpc_pkg::CFG_W-1:0] hold,
                            input logic [tbpc_pkg::CFG_W-1:0] rep);
    logic [31:0] spare;
    spare = $urandom;
    cfg_we   <= 1'b1;
    cfg_addr <= tbpc_pkg::REG_DEBOUNCE;
    cfg_data <= deb;
    @(negedge clk);
    cfg_addr <= tbpc_pkg::REG_HOLD;
    cfg_data <= hold;
    @(negedge clk);
    cfg_addr <= tbpc_pkg::REG_REPEAT;
    cfg_data <= rep;
    @(negedge clk);
    cfg_addr <= REG_SPARE;
    cfg_data <= spare[tbpc_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Each button follows a script of pressed and released stretches with
  // occasional contact bounce; a few polls are pure noise.
  task automatic timing_phase(input logic [tbpc_pkg::CFG_W-1:0] deb,
                              input logic [tbpc_pkg::CFG_W-1:0] hold,
                              input logic [tbpc_pkg::CFG_W-1:0] rep, input int polls,
                              input int step_max, input int len_max, input bit squeeze);
    logic [tbpc_pkg::STAMP_W-1:0] clock_ms;
    logic [2:0]                   target;
    logic [2:0]                   raw;
    logic [31:0]                  noise;
    int                           hold_left[tbpc_pkg::NUM_BUTTONS];
    drain();
    set_timing(deb, hold, rep);
    hold_off_req = squeeze;
    noise = $urandom;
    target = noise[2:0];
    if ($urandom_range(1) != 0) clock_ms = $urandom;
    else clock_ms = 32'hFFFF_FFFF - $urandom_range(polls * step_max / 4);
    for (int b = 0; b < tbpc_pkg::NUM_BUTTONS; b++) hold_left[b] = $urandom_range(len_max, 1);
    for (int i = 0; i < polls; i++) begin
      for (int b = 0; b < tbpc_pkg::NUM_BUTTONS; b++) begin
        if (hold_left[b] == 0) begin
          target[b] = target[b] ? 1'b0 : ($urandom_range(1) != 0);
          hold_left[b] = $urandom_range(len_max, 1);
        end
        hold_left[b]--;
        if ($urandom_range(15) == 0) raw[b] = ~target[b];
        else raw[b] = target[b];
      end
      clock_ms += $urandom_range(step_max);
      if ($urandom_range(99) == 0) begin
        noise = $urandom;
        send_poll($urandom, noise[2:0]);
      end else begin
        send_poll(clock_ms, raw);
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset timings: press all, long and held events, release after long,
    // short presses of each button, wrap and a backward timestamp.
    send_poll(32'h0000_0000, 3'b000);
    send_poll(32'hFFFF_FFFF, 3'b111);
    send_poll(32'd100, 3'b111);
    send_poll(32'd900, 3'b111);
    send_poll(32'd1050, 3'b111);
    send_poll(32'd1100, 3'b110);
    send_poll(32'd1200, 3'b110);
    send_poll(32'd1300, 3'b100);
    send_poll(32'd1400, 3'b100);
    send_poll(32'd1450, 3'b000);
    send_poll(32'd1501, 3'b000);
    send_poll(32'd1600, 3'b001);
    send_poll(32'd1700, 3'b001);
    send_poll(32'd1750, 3'b000);
    send_poll(32'd1850, 3'b000);
    send_poll(32'd1900, 3'b010);
    send_poll(32'd2000, 3'b010);
    send_poll(32'd2100, 3'b000);
    send_poll(32'd2200, 3'b000);
    send_poll(32'd1000, 3'b000);
    drain();

    // Zero timings give a long event on the first stable poll.
    set_timing('0, '0, '0);
    send_poll(32'd5, 3'b111);
    send_poll(32'd6, 3'b111);
    send_poll(32'd6, 3'b111);
    send_poll(32'd7, 3'b000);
    send_poll(32'd8, 3'b000);

    timing_phase(tbpc_pkg::DEBOUNCE_RESET, tbpc_pkg::HOLD_RESET, tbpc_pkg::REPEAT_RESET,
                 250, 60, 60, 1'b0);
    timing_phase(16'd3, 16'd20, 16'd5, 300, 4, 20, 1'b1);
    send_idle = 61;
    recv_idle = 24;
    timing_phase(16'd0, 16'd0, 16'd0, 150, 2, 8, 1'b0);
    timing_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 150, 20000, 16, 1'b0);
    timing_phase(16'd1, 16'd6, 16'hFFFF, 200, 3, 30, 1'b0);
    send_idle = 0;
    recv_idle = 0;
    timing_phase(tbpc_pkg::CFG_W'($urandom_range(8)), tbpc_pkg::CFG_W'($urandom_range(40)),
                 tbpc_pkg::CFG_W'($urandom_range(12)), 250, 6, 24, 1'b0);
    timing_phase(tbpc_pkg::CFG_W'($urandom_range(10)), tbpc_pkg::CFG_W'($urandom_range(60)),
                 tbpc_pkg::CFG_W'($urandom_range(20)), 225, 8, 30, 1'b0);
    drain();
    repeat (10) @(negedge clk);

    $display("Covered %0d polls under %0d timing settings, %0d of them raised a button event.",
             polls_sent, settings_used, events_seen);
    $display("Stimulus included bounce, timestamp wrap, backward time and a long result stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
